// File: hw/rtl/lspb_pkg.sv
// ----------------------------------------------------------------------------
// lspb_pkg
// Shared codes and types of the trajectory sample unit: register indexes,
// segment codes, configuration sequencer states and the profile bundle.
// ----------------------------------------------------------------------------
package lspb_pkg;

  localparam logic [1:0] REG_BLEND_ACCEL = 2'd0;
  localparam logic [1:0] REG_BLEND_VEL   = 2'd1;
  localparam logic [1:0] REG_TOTAL_TIME  = 2'd2;

  localparam logic [1:0] SEG_ACCEL  = 2'd0;
  localparam logic [1:0] SEG_CRUISE = 2'd1;
  localparam logic [1:0] SEG_DECEL  = 2'd2;

  typedef enum logic [2:0] {
    CFG_IDLE,
    CFG_ARM,
    CFG_DIV,
    CFG_SQ,
    CFG_MULA,
    CFG_COMB,
    CFG_MULV,
    CFG_SUM
  } cfg_state_t;

  // Per-configuration constants handed to the sample pipeline
  typedef struct packed {
    logic [30:0]        accel;
    logic [30:0]        vel;
    logic [31:0]        tb;       // blend time, Q16.16
    logic signed [33:0] tdec;     // total_time - tb
    logic [60:0]        bs;       // blend-end displacement, a*tb^2/2
    logic               bs_clip;  // bs was clipped
    logic signed [63:0] c2;       // bs + v*(total_time - 2*tb)
  } prof_t;

endpackage

// File: hw/rtl/lspb_div.sv
// ----------------------------------------------------------------------------
// lspb_div
// Restoring divider, one quotient bit per cycle: 47-bit dividend over a
// 31-bit divisor. done pulses for one cycle once the quotient is final.
// ----------------------------------------------------------------------------
module lspb_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [46:0] dividend,
  input  logic [30:0] divisor,
  output logic        done,
  output logic [46:0] quotient
);

  localparam int unsigned STEPS = 47;

  logic        run;
  logic [5:0]  cnt;
  logic [30:0] rem;
  logic [31:0] trial;
  logic        fits;

  assign trial = {rem, quotient[46]};
  assign fits  = trial >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= '0;
      end else if (run) begin
        cnt <= cnt + 6'd1;
        if (cnt == 6'(STEPS - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      quotient <= dividend;
    end else if (run) begin
      rem      <= fits ? 31'(trial - {1'b0, divisor}) : trial[30:0];
      quotient <= {quotient[45:0], fits};
    end
  end

endmodule

// File: hw/rtl/lspb_cfg.sv
// ----------------------------------------------------------------------------
// lspb_cfg
// Configuration registers and the sequencer that derives the profile
// constants (blend time, blend displacement, decel offset) after reset and
// after every register write.
// ----------------------------------------------------------------------------
module lspb_cfg import lspb_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  input  logic [1:0]  cfg_index,
  input  logic [30:0] cfg_data,
  output logic        cfg_ready,
  output logic        busy,
  output prof_t       prof
);

  cfg_state_t state, state_next;

  logic [30:0] blend_accel, blend_vel, total_time;
  logic        wr_hit;
  logic        div_start, div_done;
  logic [46:0] div_quo;

  logic [31:0]        tb;
  logic [47:0]        tbsq;
  logic [54:0]        pa_lo, pa_hi;
  logic signed [33:0] tdec;
  logic [34:0]        tdb;
  logic [60:0]        bs;
  logic               bs_clip;
  logic [64:0]        mv;
  logic signed [63:0] c2;

  logic [63:0] tb_sq_full;
  logic [78:0] pa_sum;
  logic [62:0] pa_q;
  logic [33:0] tdb_mag;
  logic [63:0] mv_s;

  assign cfg_ready = 1'b1;
  assign wr_hit = cfg_valid && (cfg_index == REG_BLEND_ACCEL ||
                                cfg_index == REG_BLEND_VEL ||
                                cfg_index == REG_TOTAL_TIME);

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= CFG_ARM;
      blend_accel <= 31'd65536;
      blend_vel   <= 31'd65536;
      total_time  <= 31'd65536;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_index == REG_BLEND_ACCEL) blend_accel <= cfg_data;
      if (cfg_valid && cfg_index == REG_BLEND_VEL)   blend_vel   <= cfg_data;
      if (cfg_valid && cfg_index == REG_TOTAL_TIME)  total_time  <= cfg_data;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      CFG_IDLE: state_next = CFG_IDLE;
      CFG_ARM:  state_next = CFG_DIV;
      CFG_DIV:  if (div_done) state_next = CFG_SQ;
      CFG_SQ:   state_next = CFG_MULA;
      CFG_MULA: state_next = CFG_COMB;
      CFG_COMB: state_next = CFG_MULV;
      CFG_MULV: state_next = CFG_SUM;
      CFG_SUM:  state_next = CFG_IDLE;
      default:  state_next = CFG_ARM;
    endcase
    // restart the derivation on any register write
    if (wr_hit) state_next = CFG_ARM;
  end

  always_comb begin
    div_start = 1'b0;
    busy      = 1'b1;
    case (state)
      CFG_IDLE: busy = 1'b0;
      CFG_ARM:  div_start = 1'b1;
      default:  busy = 1'b1;
    endcase
  end

  lspb_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend ({blend_vel, 16'b0}),
    .divisor  (blend_accel),
    .done     (div_done),
    .quotient (div_quo)
  );

  assign tb_sq_full = 64'(tb) * 64'(tb);
  assign pa_sum     = {pa_hi, 24'b0} + {24'b0, pa_lo};
  assign pa_q       = pa_sum[78:16];
  assign tdb_mag    = tdb[34] ? 34'(-tdb) : tdb[33:0];
  assign mv_s       = tdb[34] ? -{15'b0, mv[64:16]} : {15'b0, mv[64:16]};

  always_ff @(posedge clk) begin
    if (state == CFG_DIV && div_done) begin
      // zero acceleration or a long blend clips to all ones
      tb <= (blend_accel == '0 || div_quo[46:32] != '0) ? 32'hFFFF_FFFF : div_quo[31:0];
    end
    if (state == CFG_SQ) begin
      tbsq <= tb_sq_full[63:16];
      tdec <= $signed({3'b0, total_time} - {2'b0, tb});
      tdb  <= {4'b0, total_time} - {2'b0, tb, 1'b0};
    end
    if (state == CFG_MULA) begin
      pa_lo <= 55'(blend_accel) * 55'(tbsq[23:0]);
      pa_hi <= 55'(blend_accel) * 55'(tbsq[47:24]);
    end
    if (state == CFG_COMB) begin
      bs_clip <= pa_q[62];
      bs      <= pa_q[62] ? '1 : pa_q[61:1];
    end
    if (state == CFG_MULV) begin
      mv <= 65'(blend_vel) * 65'(tdb_mag);
    end
    if (state == CFG_SUM) begin
      c2 <= $signed({3'b0, bs} + mv_s);
    end
  end

  assign prof.accel   = blend_accel;
  assign prof.vel     = blend_vel;
  assign prof.tb      = tb;
  assign prof.tdec    = tdec;
  assign prof.bs      = bs;
  assign prof.bs_clip = bs_clip;
  assign prof.c2      = c2;

  a_write_rearms: assert property (@(posedge clk) disable iff (rst) wr_hit |=> busy)
    else $error("register write did not restart the derivation");

  a_zero_accel: assert property (@(posedge clk) disable iff (rst)
    (!busy && blend_accel == '0) |-> tb == 32'hFFFF_FFFF)
    else $error("zero acceleration must give the maximum blend time");

endmodule

// File: hw/rtl/lspb_pipe.sv
// ----------------------------------------------------------------------------
// lspb_pipe
// Eight-stage sample pipeline: segment select, profile products, blend
// products, velocity/acceleration scaling, position scaling and saturation.
// ----------------------------------------------------------------------------
module lspb_pipe import lspb_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic [30:0]        sample_time,
  input  logic signed [31:0] start_pos,
  input  logic signed [31:0] end_pos,
  input  prof_t              prof,
  output logic               done,
  output logic signed [31:0] position,
  output logic signed [31:0] velocity,
  output logic signed [31:0] acceleration,
  output logic [1:0]         segment,
  output logic               saturated
);

  function automatic logic [32:0] sat_mag(input logic neg, input logic [65:0] mag);
    logic [32:0] r;
    if (neg) begin
      if (mag > 66'h0_8000_0000) r = {1'b1, 32'h8000_0000};
      else r = {1'b0, 32'(-mag[31:0])};
    end else begin
      if (mag > 66'h0_7FFF_FFFF) r = {1'b1, 32'h7FFF_FFFF};
      else r = {1'b0, mag[31:0]};
    end
    return r;
  endfunction

  logic v1, v2, v3, v4, v5, v6, v7;

  // stage 1: segment select
  logic        lt_tb, lt_dec;
  logic [33:0] u_full;
  logic [31:0] tmtb;
  logic [1:0]  seg_in;
  logic [32:0] d_full;
  logic [1:0]  seg1;
  logic [32:0] x1, w1;
  logic        dneg1;
  logic [31:0] dmag1;
  logic [31:0] p01;

  assign lt_tb  = {1'b0, sample_time} < prof.tb;
  assign lt_dec = $signed({3'b0, sample_time}) < prof.tdec;
  assign u_full = {3'b0, sample_time} - prof.tdec;
  assign tmtb   = {1'b0, sample_time} - prof.tb;
  assign seg_in = lt_tb ? SEG_ACCEL : (lt_dec ? SEG_CRUISE : SEG_DECEL);
  assign d_full = {end_pos[31], end_pos} - {start_pos[31], start_pos};

  always_ff @(posedge clk) begin
    seg1  <= seg_in;
    x1    <= (seg_in == SEG_ACCEL) ? {2'b0, sample_time} : u_full[32:0];
    w1    <= (seg_in == SEG_CRUISE) ? {1'b0, tmtb} : u_full[32:0];
    dneg1 <= d_full[32];
    dmag1 <= d_full[32] ? 32'(-d_full) : d_full[31:0];
    p01   <= start_pos;
  end

  // stage 2: first products
  logic [65:0] xx_full;
  logic [63:0] ax_full, vw_full;
  logic [49:0] xx2;
  logic [47:0] ax2, vw2;
  logic [1:0]  seg2;
  logic        dneg2;
  logic [31:0] dmag2, p02;

  assign xx_full = 66'(x1) * 66'(x1);
  assign ax_full = 64'(prof.accel) * 64'(x1);
  assign vw_full = 64'(prof.vel) * 64'(w1);

  always_ff @(posedge clk) begin
    xx2   <= xx_full[65:16];
    ax2   <= ax_full[63:16];
    vw2   <= vw_full[63:16];
    seg2  <= seg1;
    dneg2 <= dneg1;
    dmag2 <= dmag1;
    p02   <= p01;
  end

  // stage 3: blend partial products, profile velocity
  logic [49:0] sd;
  logic [55:0] ah3, al3;
  logic        sdneg3;
  logic [48:0] sdmag3;
  logic [47:0] vw3;
  logic [1:0]  seg3;
  logic        dneg3;
  logic [31:0] dmag3, p03;

  always_comb begin
    case (seg2)
      SEG_ACCEL:  sd = {2'b0, ax2};
      SEG_CRUISE: sd = {19'b0, prof.vel};
      default:    sd = {19'b0, prof.vel} - {2'b0, ax2};
    endcase
  end

  always_ff @(posedge clk) begin
    ah3    <= 56'(prof.accel) * 56'(xx2[49:25]);
    al3    <= 56'(prof.accel) * 56'(xx2[24:0]);
    sdneg3 <= sd[49];
    sdmag3 <= sd[49] ? 49'(-sd) : sd[48:0];
    vw3    <= vw2;
    seg3   <= seg2;
    dneg3  <= dneg2;
    dmag3  <= dmag2;
    p03    <= p02;
  end

  // stage 4: blend term with clip, velocity/acceleration partial products
  logic [80:0] ap_sum;
  logic [64:0] ap_q;
  logic        ap_clip;
  logic [60:0] h4;
  logic        f4, vneg4, aneg4;
  logic [56:0] vl4;
  logic [55:0] vh4;
  logic [62:0] am4;
  logic [47:0] vw4;
  logic [1:0]  seg4;
  logic        dneg4;
  logic [31:0] dmag4, p04;

  assign ap_sum  = {ah3, 25'b0} + {25'b0, al3};
  assign ap_q    = ap_sum[80:16];
  assign ap_clip = ap_q[64:62] != '0;

  always_ff @(posedge clk) begin
    h4 <= ap_clip ? '1 : ap_q[61:1];
    case (seg3)
      SEG_ACCEL:  f4 <= 1'b0;
      SEG_CRUISE: f4 <= prof.bs_clip;
      default:    f4 <= prof.bs_clip | ap_clip;
    endcase
    vl4   <= 57'(dmag3) * 57'(sdmag3[24:0]);
    vh4   <= 56'(dmag3) * 56'(sdmag3[48:25]);
    am4   <= 63'(dmag3) * 63'(prof.accel);
    vneg4 <= dneg3 ^ sdneg3;
    aneg4 <= dneg3 ^ (seg3 == SEG_DECEL);
    vw4   <= vw3;
    seg4  <= seg3;
    dneg4 <= dneg3;
    dmag4 <= dmag3;
    p04   <= p03;
  end

  // stage 5: profile position, final velocity and acceleration
  logic signed [63:0] s_val;
  logic [80:0]        v_sum;
  logic [32:0]        vel_r, acc_r;
  logic signed [63:0] s5;
  logic [31:0]        vel5, acc5;
  logic               f5;
  logic [1:0]         seg5;
  logic               dneg5;
  logic [31:0]        dmag5, p05;

  assign v_sum = {vh4, 25'b0} + {24'b0, vl4};
  assign vel_r = sat_mag(vneg4, {1'b0, v_sum[80:16]});

  always_comb begin
    case (seg4)
      SEG_ACCEL:  s_val = $signed({3'b0, h4});
      SEG_CRUISE: s_val = $signed({3'b0, prof.bs} + {16'b0, vw4});
      default:    s_val = prof.c2 + $signed({16'b0, vw4}) - $signed({3'b0, h4});
    endcase
    if (seg4 == SEG_CRUISE) acc_r = '0;
    else acc_r = sat_mag(aneg4, {19'b0, am4[62:16]});
  end

  always_ff @(posedge clk) begin
    s5    <= s_val;
    vel5  <= vel_r[31:0];
    acc5  <= acc_r[31:0];
    f5    <= f4 | vel_r[32] | acc_r[32];
    seg5  <= seg4;
    dneg5 <= dneg4;
    dmag5 <= dmag4;
    p05   <= p04;
  end

  // stage 6: magnitude of the profile position
  logic [62:0] smag6;
  logic        mneg6;
  logic [31:0] vel6, acc6, dmag6, p06;
  logic        f6;
  logic [1:0]  seg6;

  always_ff @(posedge clk) begin
    smag6 <= s5[63] ? 63'(-s5) : s5[62:0];
    mneg6 <= dneg5 ^ s5[63];
    vel6  <= vel5;
    acc6  <= acc5;
    f6    <= f5;
    seg6  <= seg5;
    dmag6 <= dmag5;
    p06   <= p05;
  end

  // stage 7: position partial products
  logic [63:0] ml7;
  logic [62:0] mh7;
  logic        mneg7, f7;
  logic [31:0] vel7, acc7, p07;
  logic [1:0]  seg7;

  always_ff @(posedge clk) begin
    ml7   <= 64'(dmag6) * 64'(smag6[31:0]);
    mh7   <= 63'(dmag6) * 63'(smag6[62:32]);
    mneg7 <= mneg6;
    vel7  <= vel6;
    acc7  <= acc6;
    f7    <= f6;
    seg7  <= seg6;
    p07   <= p06;
  end

  // stage 8: offset by start position and saturate
  logic [94:0] m_sum;
  logic [78:0] m_q;
  logic [33:0] mc;
  logic [34:0] ms;
  logic [35:0] psum;
  logic        psat;

  assign m_sum = {mh7, 32'b0} + {31'b0, ml7};
  assign m_q   = m_sum[94:16];
  // anything at or above 2^33 saturates the same way; hold it there
  assign mc    = (m_q[78:33] != '0) ? 34'h2_0000_0000 : {1'b0, m_q[32:0]};
  assign ms    = mneg7 ? -{1'b0, mc} : {1'b0, mc};
  assign psum  = {{4{p07[31]}}, p07} + {ms[34], ms};
  assign psat  = !(psum[35:31] == 5'b00000 || psum[35:31] == 5'b11111);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      v2   <= 1'b0;
      v3   <= 1'b0;
      v4   <= 1'b0;
      v5   <= 1'b0;
      v6   <= 1'b0;
      v7   <= 1'b0;
      done <= 1'b0;
    end else begin
      v1   <= in_valid;
      v2   <= v1;
      v3   <= v2;
      v4   <= v3;
      v5   <= v4;
      v6   <= v5;
      v7   <= v6;
      done <= v7;
    end
  end

  always_ff @(posedge clk) begin
    if (psat) position <= psum[35] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    else position <= $signed(psum[31:0]);
    velocity     <= $signed(vel7);
    acceleration <= $signed(acc7);
    segment      <= seg7;
    saturated    <= f7 | psat;
  end

  a_cruise_no_accel: assert property (@(posedge clk) disable iff (rst)
    (done && segment == SEG_CRUISE) |-> acceleration == '0)
    else $error("cruise sample with nonzero acceleration");

endmodule

// File: hw/rtl/lspb_trajectory_sample_unit.sv
// ----------------------------------------------------------------------------
// lspb_trajectory_sample_unit
// Linear-segment-with-parabolic-blend sampler for one joint, Q16.16.
// ----------------------------------------------------------------------------
// A sample is taken at every clock edge where start is high and busy is low,
// one per cycle sustained; its result appears on the result ports with done
// high once it leaves the sample pipeline, for one cycle only, as the receiver
// cannot stall. After reset and after every register write busy stays high
// while the blend time is divided out (47-step serial divider) and the blend
// constants are formed; configuration writes are always taken (cfg_ready is
// tied high).
// ----------------------------------------------------------------------------
module lspb_trajectory_sample_unit import lspb_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [30:0]        sample_time,
  input  logic signed [31:0] start_pos,
  input  logic signed [31:0] end_pos,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [30:0]        cfg_data,
  output logic               done,
  output logic signed [31:0] position,
  output logic signed [31:0] velocity,
  output logic signed [31:0] acceleration,
  output logic [1:0]         segment,
  output logic               saturated
);

  prof_t prof;

  lspb_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg_ready (cfg_ready),
    .busy      (busy),
    .prof      (prof)
  );

  lspb_pipe u_pipe (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (start && !busy),
    .sample_time  (sample_time),
    .start_pos    (start_pos),
    .end_pos      (end_pos),
    .prof         (prof),
    .done         (done),
    .position     (position),
    .velocity     (velocity),
    .acceleration (acceleration),
    .segment      (segment),
    .saturated    (saturated)
  );

endmodule
